/* rtl/core/swsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsf_pkg
// Shared types, constants and frame helpers for the stopwatch frame core.
// ----------------------------------------------------------------------------
package swsf_pkg;

  // field widths
  localparam int unsigned HundW   = 7;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned PeriodW = 7;
  localparam int unsigned ByteW   = 8;

  // frame geometry
  localparam int unsigned FrameLen = 15;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FrameLen - 1);

  // counter wrap points
  localparam logic [HundW:0] HundWrap = (HundW+1)'(100);
  localparam logic [SecW:0]  SecWrap  = (SecW+1)'(60);
  localparam logic [MinW:0]  MinWrap  = (MinW+1)'(60);

  // led period after reset
  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(101);

  // ascii codes used in the frame
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiColon = 8'h3A;
  localparam logic [ByteW-1:0] AsciiLt    = 8'h3C;
  localparam logic [ByteW-1:0] AsciiX     = 8'h78;
  localparam logic [ByteW-1:0] AsciiD     = 8'h44;
  localparam logic [ByteW-1:0] AsciiGt    = 8'h3E;

  // time and status captured for one request
  typedef struct packed {
    logic            counted;
    logic [MinW-1:0] minutes;
    logic [SecW-1:0] seconds;
    logic [HundW-1:0] hundredths;
    logic            led;
    logic            running;
  } snap_t;

  // tens digit of a value below 100, by threshold count
  function automatic logic [3:0] tens_digit(input logic [HundW-1:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (v >= HundW'(k * 10)) t = t + 4'd1;
    end
    return t;
  endfunction

  // ascii digit pair of a value below 100
  function automatic logic [2*ByteW-1:0] ascii_pair(input logic [HundW-1:0] v);
    logic [3:0]       t;
    logic [HundW-1:0] ones;
    t    = tens_digit(v);
    ones = v - HundW'(t * 10);
    return {AsciiZero + ByteW'(t), AsciiZero + ByteW'(ones)};
  endfunction

  // one byte of the frame "MM:SS:CC:<0x0D>"
  function automatic logic [ByteW-1:0] frame_byte(input logic [IdxW-1:0] idx,
                                                  input snap_t s);
    logic [2*ByteW-1:0] mm;
    logic [2*ByteW-1:0] ss;
    logic [2*ByteW-1:0] cc;
    logic [ByteW-1:0]   b;
    mm = ascii_pair(HundW'(s.minutes));
    ss = ascii_pair(HundW'(s.seconds));
    cc = ascii_pair(s.hundredths);
    case (idx)
      4'd0:    b = mm[2*ByteW-1:ByteW];
      4'd1:    b = mm[ByteW-1:0];
      4'd2:    b = AsciiColon;
      4'd3:    b = ss[2*ByteW-1:ByteW];
      4'd4:    b = ss[ByteW-1:0];
      4'd5:    b = AsciiColon;
      4'd6:    b = cc[2*ByteW-1:ByteW];
      4'd7:    b = cc[ByteW-1:0];
      4'd8:    b = AsciiColon;
      4'd9:    b = AsciiLt;
      4'd10:   b = AsciiZero;
      4'd11:   b = AsciiX;
      4'd12:   b = AsciiZero;
      4'd13:   b = AsciiD;
      4'd14:   b = AsciiGt;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/swsf_state.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsf_state
// Stopwatch time, run state, button edge and led counter, updated once per
// accepted poll; presents the state after the poll as a snapshot.
// ----------------------------------------------------------------------------
module swsf_state (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         accept_i,
  input  wire logic                         tick_i,
  input  wire logic                         start_button_i,
  input  wire logic                         reset_button_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [swsf_pkg::PeriodW-1:0] cfg_data_i,
  output swsf_pkg::snap_t                   snap_o
);
  import swsf_pkg::*;

  logic [HundW-1:0]   hund_q, hund_d;
  logic [SecW-1:0]    sec_q, sec_d;
  logic [MinW-1:0]    min_q, min_d;
  logic               run_q, run_d;
  logic               held_q, held_d;
  logic               led_q, led_d;
  logic [PeriodW-1:0] cnt_q, cnt_d;
  logic [PeriodW-1:0] period_q;

  logic               counted;
  logic [HundW:0]     hund_inc;
  logic [SecW:0]      sec_inc;
  logic [MinW:0]      min_inc;
  logic               hund_wrap;
  logic               sec_wrap;
  logic [PeriodW-1:0] cnt_inc;

  // next state for one poll
  always_comb begin
    counted  = tick_i && run_q;
    hund_inc = {1'b0, hund_q} + (HundW+1)'(1);
    hund_wrap = (hund_inc >= HundWrap);
    sec_inc  = {1'b0, sec_q} + (SecW+1)'(hund_wrap);
    sec_wrap = (sec_inc >= SecWrap);
    min_inc  = {1'b0, min_q} + (MinW+1)'(sec_wrap);
    cnt_inc  = cnt_q + PeriodW'(1);

    hund_d = hund_q;
    sec_d  = sec_q;
    min_d  = min_q;
    led_d  = led_q;
    cnt_d  = cnt_q;
    run_d  = run_q;

    // counted tick advances time and led counter
    if (counted) begin
      hund_d = hund_wrap ? '0 : hund_inc[HundW-1:0];
      sec_d  = sec_wrap ? '0 : sec_inc[SecW-1:0];
      min_d  = (min_inc >= MinWrap) ? '0 : min_inc[MinW-1:0];
      if (cnt_inc == period_q) begin
        led_d = ~led_q;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end

    // press edge toggles running
    if (start_button_i && !held_q) run_d = ~run_d;

    // held reset button clears time, run and led
    if (reset_button_i) begin
      hund_d = '0;
      sec_d  = '0;
      min_d  = '0;
      run_d  = 1'b0;
      led_d  = 1'b0;
    end

    held_d = start_button_i;
  end

  // snapshot after the poll
  always_comb begin
    snap_o.counted    = counted;
    snap_o.minutes    = min_d;
    snap_o.seconds    = sec_d;
    snap_o.hundredths = hund_d;
    snap_o.led        = led_d;
    snap_o.running    = run_d;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hund_q   <= '0;
      sec_q    <= '0;
      min_q    <= '0;
      run_q    <= 1'b0;
      held_q   <= 1'b0;
      led_q    <= 1'b0;
      cnt_q    <= '0;
      period_q <= PeriodReset;
    end else begin
      if (accept_i) begin
        hund_q <= hund_d;
        sec_q  <= sec_d;
        min_q  <= min_d;
        run_q  <= run_d;
        held_q <= held_d;
        led_q  <= led_d;
        cnt_q  <= cnt_d;
      end
      if (cfg_we_i) period_q <= cfg_data_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/swsf_frame.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swsf_frame
// Result register and frame byte sequencer: holds one status result or
// walks the fifteen bytes of a frame, one per taken result.
// ----------------------------------------------------------------------------
module swsf_frame (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire swsf_pkg::snap_t            snap_i,
  output logic                            room_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [swsf_pkg::ByteW-1:0]      tx_byte_o,
  output logic                            byte_valid_o,
  output logic                            last_o,
  output logic                            led_on_o,
  output logic                            running_now_o
);
  import swsf_pkg::*;

  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  snap_t           snap_q;
  logic            last;

  // last result of the current request
  assign last   = !snap_q.counted || (idx_q == IdxLast);
  assign room_o = !valid_q || (out_ready_i && last);

  // result register and byte counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last) valid_q <= 1'b0;
      else idx_q <= idx_q + IdxW'(1);
    end
  end

  // captured time, no reset needed
  always_ff @(posedge clk_i) begin
    if (load_i) snap_q <= snap_i;
  end

  // result fields
  assign out_valid_o   = valid_q;
  assign byte_valid_o  = snap_q.counted;
  assign tx_byte_o     = snap_q.counted ? frame_byte(idx_q, snap_q) : '0;
  assign last_o        = last;
  assign led_on_o      = snap_q.led;
  assign running_now_o = snap_q.running;

endmodule
`default_nettype wire

/* rtl/core/stopwatch_with_serial_frame_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stopwatch_with_serial_frame_core
// Minutes/seconds/hundredths stopwatch polled once per request, emitting a
// fifteen-byte ascii time frame after each counted tick.
// ----------------------------------------------------------------------------
// Each accepted poll updates the stopwatch in the cycle it is taken and its
// results appear from the next cycle. A poll without a counted tick gives one
// status result, so such polls flow at one per cycle while results are taken.
// A counted tick gives fifteen results, one per cycle taken, from the frame
// byte counter; the next poll is accepted in the cycle the last byte is taken.
// The led period register may be written at any time the block is idle.
module stopwatch_with_serial_frame_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [swsf_pkg::PeriodW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         tick_i,
  input  wire logic                         start_button_i,
  input  wire logic                         reset_button_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [swsf_pkg::ByteW-1:0]        tx_byte_o,
  output logic                              byte_valid_o,
  output logic                              last_o,
  output logic                              led_on_o,
  output logic                              running_now_o
);
  import swsf_pkg::*;

  snap_t snap;
  logic  room;
  logic  accept;

  // request handshake
  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  // stopwatch state
  swsf_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .tick_i         (tick_i),
    .start_button_i (start_button_i),
    .reset_button_i (reset_button_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .snap_o         (snap)
  );

  // result sequencer
  swsf_frame u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept),
    .snap_i        (snap),
    .room_o        (room),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_byte_o     (tx_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_o        (last_o),
    .led_on_o      (led_on_o),
    .running_now_o (running_now_o)
  );

  // a status result is always the last of its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> last_o)
    else $error("status result without last");

  // frame bytes are printable, never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> (tx_byte_o != '0))
    else $error("zero byte inside frame");

  // an accepted request shows a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> out_valid_o)
    else $error("accepted request produced no result");

  // reset button leaves the stopwatch stopped with the led off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && reset_button_i) |=> (!running_now_o && !led_on_o))
    else $error("reset button did not stop the stopwatch");

endmodule
`default_nettype wire
